### hw/rtl/safety_switch_pulse_code_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property macros for the pulse-code decoder; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SAFETY_SWITCH_PULSE_CODE_DECODER_ASSERT_SVH
`define SAFETY_SWITCH_PULSE_CODE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// checked on every rising edge outside reset
`define SSPCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every rising edge, reset included
`define SSPCD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SSPCD_ASSERT(label, prop, msg)
`define SSPCD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### hw/rtl/sspcd_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-code decoder package
// Shared widths, register indexes, mode codes and types.
// ----------------------------------------------------------------------------
package sspcd_pkg;

   localparam int COUNT_WIDTH_DEF = 8;
   localparam int TIMER_WIDTH_DEF = 16;

   localparam int CODE_W        = 8;
   localparam int MODE_W        = 2;
   localparam int WINDOW_W      = 8;
   localparam int TIMEOUT_W     = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd2;

   // decode modes
   localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WINDOW = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GATED  = 2'd2;

   // register reset values
   localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 8'd100;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd100;

   typedef struct packed {
      logic [MODE_W-1:0]    decode_mode;
      logic [WINDOW_W-1:0]  window_clocks;
      logic [TIMEOUT_W-1:0] gate_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic clock_line;
      logic serial_line;
      logic reset_request;
   } sample_type;

endpackage

### hw/rtl/sspcd_if.sv
// ----------------------------------------------------------------------------
// Pulse-code decoder channels
// Valid/ready channels for sample requests and decoded results.
// ----------------------------------------------------------------------------
interface sspcd_req_if;
   logic valid;
   logic ready;
   logic clock_line;
   logic serial_line;
   logic reset_request;

   modport source (output valid, output clock_line, output serial_line,
                   output reset_request, input ready);
   modport sink   (input valid, input clock_line, input serial_line,
                   input reset_request, output ready);
endinterface

interface sspcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] alarm_code;
   logic       alarm_one_flag;

   modport source (output valid, output alarm_code, output alarm_one_flag, input ready);
   modport sink   (input valid, input alarm_code, input alarm_one_flag, output ready);
endinterface

### hw/rtl/safety_switch_pulse_code_decoder.sv
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the single result
//   register takes a new result in the same cycle the previous one is taken.
// A stalled result blocks new requests until it is taken.
// Reset (synchronous, active high): decoder state cleared, registers back to
//   mode 0, window 100, timeout 100; no result pending.
// ----------------------------------------------------------------------------
// Safety switch pulse-code decoder
// Decodes sampled clock/serial diagnostic lines into an alarm code per tick.
// ----------------------------------------------------------------------------
module safety_switch_pulse_code_decoder
   import sspcd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,   // pulse counter width, 7..16
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF    // gate timer width, 8..32
) (
   input  logic                   clock,
   input  logic                   reset,
   sspcd_req_if.sink              req_chan,
   sspcd_rsp_if.source            rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   sample_type sample;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // ---------------------------------------------------------------------
   // Configuration registers; an index past the list is dropped.
   // ---------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:    cfg_in.decode_mode        = csr_wdata[MODE_W-1:0];
            CSR_WINDOW:  cfg_in.window_clocks      = csr_wdata[WINDOW_W-1:0];
            CSR_TIMEOUT: cfg_in.gate_timeout_ticks = csr_wdata[TIMEOUT_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode        <= MODE_OFF;
         cfg_ff.window_clocks      <= WINDOW_RST;
         cfg_ff.gate_timeout_ticks <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake. The decoder's latched code and sticky flag are the result
   // register: they change only on an accepted request, and a request is
   // accepted only when the slot is empty or being emptied this cycle.
   // ---------------------------------------------------------------------
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_valid_in   = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sample.clock_line    = req_chan.clock_line;
   assign sample.serial_line   = req_chan.serial_line;
   assign sample.reset_request = req_chan.reset_request;

   // ---------------------------------------------------------------------
   // Decoder: edge detect, counters and latch in one pass per request.
   // ---------------------------------------------------------------------
   sspcd_core #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .sample         (sample),
      .cfg            (cfg_ff),
      .alarm_code     (rsp_chan.alarm_code),
      .alarm_one_flag (rsp_chan.alarm_one_flag)
   );

   assign rsp_chan.valid = rsp_valid_ff;

endmodule

### hw/rtl/sspcd_core.sv
// ----------------------------------------------------------------------------
// Pulse-code decoder core
// Decoder state and one-pass next-state logic, updated per accepted request.
// ----------------------------------------------------------------------------
`include "safety_switch_pulse_code_decoder_assert.svh"

module sspcd_core
   import sspcd_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  sample_type        sample,
   input  cfg_type           cfg,
   output logic [CODE_W-1:0] alarm_code,
   output logic              alarm_one_flag
);

   localparam int CmpW = (COUNT_WIDTH > WINDOW_W)  ? COUNT_WIDTH : WINDOW_W;
   localparam int TmW  = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

   logic                   last_clock_ff, last_clock_in;
   logic                   gate_open_ff, gate_open_in;
   logic                   last_gate_open_ff, last_gate_open_in;
   logic                   last_serial_ff, last_serial_in;
   logic [COUNT_WIDTH-1:0] clock_pulse_count_ff, clock_pulse_count_in;
   logic [COUNT_WIDTH-1:0] serial_pulse_count_ff, serial_pulse_count_in;
   logic [TIMER_WIDTH-1:0] gate_timer_ff, gate_timer_in;
   logic [CODE_W-1:0]      latched_code_ff, latched_code_in;
   logic                   sticky_alarm_ff, sticky_alarm_in;
   logic                   mode_active;
   logic                   timed_out;

   assign mode_active = (cfg.decode_mode == MODE_WINDOW) || (cfg.decode_mode == MODE_GATED);

   always_comb begin
      last_clock_in         = last_clock_ff;
      gate_open_in          = gate_open_ff;
      last_gate_open_in     = last_gate_open_ff;
      last_serial_in        = last_serial_ff;
      clock_pulse_count_in  = clock_pulse_count_ff;
      serial_pulse_count_in = serial_pulse_count_ff;
      gate_timer_in         = gate_timer_ff;
      latched_code_in       = latched_code_ff;
      sticky_alarm_in       = sticky_alarm_ff;
      timed_out             = 1'b0;

      if (accept && mode_active) begin
         if (sample.reset_request) begin
            last_clock_in         = 1'b0;
            gate_open_in          = 1'b0;
            last_gate_open_in     = 1'b0;
            last_serial_in        = 1'b0;
            clock_pulse_count_in  = '0;
            serial_pulse_count_in = '0;
            gate_timer_in         = '0;
            latched_code_in       = '0;
            sticky_alarm_in       = 1'b0;
         end

         if (cfg.decode_mode == MODE_WINDOW) begin
            // gate follows the clock high phase, first serial high closes it
            if (sample.clock_line && !last_clock_in) begin
               gate_open_in = 1'b1;
            end
            if (!sample.clock_line) begin
               gate_open_in = 1'b0;
            end
            last_clock_in = sample.clock_line;

            if (gate_open_in && !last_gate_open_in && (clock_pulse_count_in != '1)) begin
               clock_pulse_count_in = clock_pulse_count_in + 1'b1;
            end
            last_gate_open_in = gate_open_in;

            if (gate_open_in && sample.serial_line) begin
               gate_open_in = 1'b0;
               if (serial_pulse_count_in != '1) begin
                  serial_pulse_count_in = serial_pulse_count_in + 1'b1;
               end
            end

            if (CmpW'(clock_pulse_count_in) > CmpW'(cfg.window_clocks)) begin
               latched_code_in       = CODE_W'(serial_pulse_count_in);
               serial_pulse_count_in = '0;
               clock_pulse_count_in  = '0;
            end
         end else begin
            // gate opens on clock fall, closes on clock high or timeout
            if (!sample.clock_line && last_clock_in) begin
               gate_open_in = 1'b1;
            end
            last_clock_in = sample.clock_line;

            if (!gate_open_in) begin
               gate_timer_in = '0;
            end else if (gate_timer_in != '1) begin
               gate_timer_in = gate_timer_in + 1'b1;
            end
            timed_out = gate_open_in && (TmW'(gate_timer_in) >= TmW'(cfg.gate_timeout_ticks));

            if (sample.clock_line || timed_out) begin
               gate_open_in = 1'b0;
            end

            if (gate_open_in && sample.serial_line && !last_serial_in &&
                (serial_pulse_count_in != '1)) begin
               serial_pulse_count_in = serial_pulse_count_in + 1'b1;
            end
            last_serial_in = sample.serial_line;

            if (!gate_open_in) begin
               if (last_gate_open_in) begin
                  latched_code_in = CODE_W'(serial_pulse_count_in);
               end
               serial_pulse_count_in = '0;
            end
            last_gate_open_in = gate_open_in;
         end

         if (latched_code_in == CODE_W'(1)) begin
            sticky_alarm_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clock_ff         <= 1'b0;
         gate_open_ff          <= 1'b0;
         last_gate_open_ff     <= 1'b0;
         last_serial_ff        <= 1'b0;
         clock_pulse_count_ff  <= '0;
         serial_pulse_count_ff <= '0;
         gate_timer_ff         <= '0;
         latched_code_ff       <= '0;
         sticky_alarm_ff       <= 1'b0;
      end else begin
         last_clock_ff         <= last_clock_in;
         gate_open_ff          <= gate_open_in;
         last_gate_open_ff     <= last_gate_open_in;
         last_serial_ff        <= last_serial_in;
         clock_pulse_count_ff  <= clock_pulse_count_in;
         serial_pulse_count_ff <= serial_pulse_count_in;
         gate_timer_ff         <= gate_timer_in;
         latched_code_ff       <= latched_code_in;
         sticky_alarm_ff       <= sticky_alarm_in;
      end
   end

   assign alarm_code     = latched_code_ff;
   assign alarm_one_flag = sticky_alarm_ff;

   // sticky flag drops only through a reset or an accepted reset request
   `SSPCD_ASSERT(a_sticky_holds, $fell(sticky_alarm_ff) |-> ($past(reset) || $past(accept && sample.reset_request && mode_active)), "sticky alarm cleared without reset")
   // state moves only on an accepted request in an active mode
   `SSPCD_ASSERT(a_state_frozen, (!$past(reset) && !$past(accept && mode_active)) |-> ($stable(latched_code_ff) && $stable(clock_pulse_count_ff) && $stable(gate_timer_ff) && $stable(serial_pulse_count_ff)), "decoder state moved while frozen")
   // a fresh latch in window mode restarts the clock count
   `SSPCD_ASSERT(a_window_restart, ($past(accept && mode_active && !sample.reset_request) && ($past(cfg.decode_mode) == MODE_WINDOW) && (latched_code_ff != $past(latched_code_ff))) |-> (clock_pulse_count_ff == '0), "window latch left clock count")
   // reset leaves a clean result
   `SSPCD_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> (!sticky_alarm_ff && (latched_code_ff == '0)), "result not cleared by reset")

endmodule
